// ===== rtl/pts_pkg.sv =====
// Shared types and codes for the periodic task scheduler.
// Used by the channel interfaces, the task cell and the top level.
package pts_pkg;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_TICK = 2'd1,
      KIND_END  = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RSN_END     = 2'd0,
      RSN_PREEMPT = 2'd1,
      RSN_FINISH  = 2'd2,
      RSN_MISS    = 2'd3
   } reason_type;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_LOAD    = 3'd1,
      OP_RELEASE = 3'd2,
      OP_RUN     = 3'd3,
      OP_MISS    = 3'd4,
      OP_END     = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      CSR_TASK_COUNT = 4'd0,
      CSR_POLICY     = 4'd1
   } csr_index_type;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_REL  = 6'b000010,
      ST_SEL  = 6'b000100,
      ST_RUN  = 6'b001000,
      ST_MISS = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   typedef struct packed {
      logic        result_kind;
      logic [3:0]  slot;
      logic        idle;
      logic [31:0] duration;
      logic [1:0]  reason;
      logic [31:0] completed;
      logic [31:0] missed;
   } rsp_type;

endpackage

// ===== rtl/pts_if.sv =====
// Valid/ready channel interfaces: task requests, results and register writes.
// Depends on pts_pkg for field widths.
interface pts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [3:0]  task_req;
   logic [15:0] period;
   logic [15:0] deadline;
   logic [15:0] burst;
   modport source (output valid, kind, task_req, period, deadline, burst, input ready);
   modport sink (input valid, kind, task_req, period, deadline, burst, output ready);
endinterface

interface pts_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [3:0]  slot;
   logic        idle;
   logic [31:0] duration;
   logic [1:0]  reason;
   logic [31:0] completed;
   logic [31:0] missed;
   logic        last;
   modport source (output valid, result_kind, slot, idle, duration, reason, completed,
                   missed, last, input ready);
   modport sink (input valid, result_kind, slot, idle, duration, reason, completed,
                 missed, last, output ready);
endinterface

interface pts_csr_if;
   import pts_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pts_cell.sv =====
// One task entry of the scheduler: timing table, job state and counters.
// Also one stage of the priority chain. Depends on pts_pkg.
module pts_cell
   import pts_pkg::*;
#(
   parameter int INDEX     = 0,
   parameter int IDW       = 5,
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  op_type               op,
   input  logic [IDW-1:0]       op_idx,
   input  logic [TIME_BITS-1:0] t_now,
   input  logic [TIME_BITS-1:0] t_next,
   input  logic [15:0]          ld_period,
   input  logic [15:0]          ld_deadline,
   input  logic [15:0]          ld_burst,
   input  logic [4:0]           task_count,
   input  logic                 policy_mode,
   input  logic                 ch_valid_i,
   input  logic [IDW-1:0]       ch_idx_i,
   input  logic [TIME_BITS-1:0] ch_key_i,
   input  logic [15:0]          ch_rem_i,
   output logic                 ch_valid_o,
   output logic [IDW-1:0]       ch_idx_o,
   output logic [TIME_BITS-1:0] ch_key_o,
   output logic [15:0]          ch_rem_o,
   output logic                 miss_hit,
   output logic [31:0]          completed,
   output logic [31:0]          missed
);

   logic [15:0]          period_ff, deadline_ff, burst_ff, rem_ff;
   logic [TIME_BITS-1:0] arrive_ff, absdl_ff;
   logic                 ready_ff;
   logic [31:0]          comp_ff, miss_ff;
   logic                 ch_valid_ff;
   logic [IDW-1:0]       ch_idx_ff;
   logic [TIME_BITS-1:0] ch_key_ff;
   logic [15:0]          ch_rem_ff;

   logic                 in_use, own_ok, take_own, selected;
   logic [TIME_BITS-1:0] own_key;

   assign in_use   = int'(task_count) > INDEX;
   assign selected = (op_idx == IDW'(INDEX));
   assign miss_hit = in_use && ready_ff && (rem_ff != 16'd0) && (absdl_ff == t_next);
   assign own_key  = policy_mode ? absdl_ff : TIME_BITS'(period_ff);
   assign own_ok   = in_use && ready_ff;
   // Strict compare: on a tie the lower index coming from the left keeps the slot.
   assign take_own = own_ok && (!ch_valid_i || (own_key < ch_key_i));

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_valid_ff <= 1'b0;
      end else begin
         ch_valid_ff <= take_own || ch_valid_i;
      end
      ch_idx_ff <= take_own ? IDW'(INDEX) : ch_idx_i;
      ch_key_ff <= take_own ? own_key : ch_key_i;
      ch_rem_ff <= take_own ? rem_ff : ch_rem_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         arrive_ff <= '0;
         comp_ff   <= '0;
         miss_ff   <= '0;
      end else begin
         case (op)
            OP_LOAD: begin
               if (selected) begin
                  period_ff   <= ld_period;
                  deadline_ff <= ld_deadline;
                  burst_ff    <= ld_burst;
                  rem_ff      <= ld_burst;
                  arrive_ff   <= '0;
                  absdl_ff    <= TIME_BITS'(ld_deadline);
                  ready_ff    <= 1'b0;
                  comp_ff     <= '0;
                  miss_ff     <= '0;
               end
            end
            OP_RELEASE: begin
               if (in_use && arrive_ff == t_now) begin
                  rem_ff   <= burst_ff;
                  absdl_ff <= t_now + TIME_BITS'(deadline_ff);
                  ready_ff <= 1'b1;
               end
            end
            OP_RUN: begin
               if (selected) begin
                  rem_ff <= rem_ff - 16'd1;
                  if (rem_ff == 16'd1) begin
                     comp_ff   <= comp_ff + 32'd1;
                     ready_ff  <= 1'b0;
                     arrive_ff <= arrive_ff + TIME_BITS'(period_ff);
                  end
               end
            end
            OP_MISS: begin
               if (miss_hit) begin
                  miss_ff   <= miss_ff + 32'd1;
                  rem_ff    <= 16'd0;
                  ready_ff  <= 1'b0;
                  arrive_ff <= arrive_ff + TIME_BITS'(period_ff);
               end
            end
            OP_END: begin
               arrive_ff <= '0;
               ready_ff  <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign ch_valid_o = ch_valid_ff;
   assign ch_idx_o   = ch_idx_ff;
   assign ch_key_o   = ch_key_ff;
   assign ch_rem_o   = ch_rem_ff;
   assign completed  = comp_ff;
   assign missed     = miss_ff;

endmodule

// ===== rtl/periodic_task_scheduler_rm_edf_core.sv =====
// Top level of the periodic task scheduler: sequencer, event queue and cell row.
// Depends on pts_pkg, the channel interfaces in pts_if and pts_cell.
//
// Channels: req_ch carries load, tick, end and read beats; rsp_ch returns
// slice events and counter reports, the final beat of one request flagged
// by last; csr_ch writes task_count (index 0) and policy_mode (index 1) and
// is always ready.
// Load beats that pass the load check take effect in the cycle they are
// accepted. A read or end beat ends once its results are sent. A tick has
// at most two results and runs these steps: the accept step, a release
// step, a selection step while the best candidate ripples down the row of
// task cells, a run step and a deadline check step, then its results are
// sent.
// The block takes one request at a time; req_ch.ready is high again once
// all results of the previous request are in the output register.
// A stalled rsp_ch holds the output register and the sequencer waits.
// Reset (synchronous) empties the task queue state, sets time to zero and
// task_count to 1, policy to rate monotonic; table entries are undefined
// until loaded.
module periodic_task_scheduler_rm_edf_core
   import pts_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   pts_req_if.sink    req_ch,
   pts_rsp_if.source  rsp_ch,
   pts_csr_if.sink    csr_ch
);

   localparam int IDW = $clog2(MAX_TASKS + 1);
   localparam logic [IDW-1:0] IDLE_CODE = IDW'(MAX_TASKS);

   state_type             state_ff, state_in;
   logic [4:0]            task_count_ff;
   logic                  policy_ff;
   logic [IDW-1:0]        running_ff, running_in;
   logic [TIME_BITS-1:0]  start_ff, start_in, time_ff, time_in, t_next;
   logic [IDW-1:0]        sel_cnt_ff, sel_cnt_in;
   rsp_type               ev_ff [2];
   rsp_type               ev_in [2];
   logic [1:0]            ev_cnt_ff, ev_cnt_in;
   logic                  ev_ptr_ff, ev_ptr_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   op_type                op;
   logic [IDW-1:0]        op_idx;
   logic                  req_fire, load_ok;

   logic [MAX_TASKS:0]    ch_valid;
   logic [IDW-1:0]        ch_idx [MAX_TASKS+1];
   logic [TIME_BITS-1:0]  ch_key [MAX_TASKS+1];
   logic [15:0]           ch_rem [MAX_TASKS+1];
   logic [MAX_TASKS-1:0]  hit;
   logic [31:0]           comp [MAX_TASKS];
   logic [31:0]           miss [MAX_TASKS];

   function automatic rsp_type slice_ev(logic [IDW-1:0] tid, logic [TIME_BITS-1:0] dur,
                                        reason_type why);
      rsp_type r;
      r.result_kind = 1'b0;
      r.idle        = (tid == IDLE_CODE);
      r.slot        = (tid == IDLE_CODE) ? 4'd0 : 4'(tid);
      r.duration    = 32'(dur);
      r.reason      = why;
      r.completed   = '0;
      r.missed      = '0;
      return r;
   endfunction

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign t_next       = time_ff + TIME_BITS'(1);
   assign load_ok      = (int'(req_ch.task_req) < MAX_TASKS) && (req_ch.burst != 16'd0) &&
                         (req_ch.burst <= req_ch.deadline) &&
                         (req_ch.deadline <= req_ch.period);

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= 5'd1;
         policy_ff     <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_TASK_COUNT: task_count_ff <= csr_ch.data[4:0];
            CSR_POLICY:     policy_ff     <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_type rep;
      logic [IDW-1:0]       sel;
      logic [TIME_BITS-1:0] st;
      logic                 run_hit;
      state_in     = state_ff;
      running_in   = running_ff;
      start_in     = start_ff;
      time_in      = time_ff;
      sel_cnt_in   = sel_cnt_ff;
      ev_in        = ev_ff;
      ev_cnt_in    = ev_cnt_ff;
      ev_ptr_in    = ev_ptr_ff;
      rsp_in       = rsp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      op           = OP_NONE;
      op_idx       = IDW'(req_ch.task_req);
      sel          = ch_valid[MAX_TASKS] ? ch_idx[MAX_TASKS] : IDLE_CODE;
      st           = start_ff;
      run_hit      = 1'b0;
      rep.result_kind = 1'b1;
      rep.slot        = req_ch.task_req;
      rep.idle        = 1'b0;
      rep.duration    = '0;
      rep.reason      = RSN_END;
      rep.completed   = '0;
      rep.missed      = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (int'(req_ch.task_req) == i) begin
            rep.completed = comp[i];
            rep.missed    = miss[i];
         end
         if (hit[i] && running_ff == IDW'(i)) begin
            run_hit = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            ev_cnt_in = 2'd0;
            ev_ptr_in = 1'b0;
            if (req_fire) begin
               case (req_ch.kind)
                  KIND_LOAD: begin
                     if (load_ok) begin
                        op = OP_LOAD;
                     end
                  end
                  KIND_TICK: begin
                     state_in = ST_REL;
                  end
                  KIND_END: begin
                     op = OP_END;
                     if (time_ff != start_ff) begin
                        ev_in[0]  = slice_ev(running_ff, time_ff - start_ff, RSN_END);
                        ev_cnt_in = 2'd1;
                        state_in  = ST_EMIT;
                     end
                     time_in    = '0;
                     start_in   = '0;
                     running_in = IDLE_CODE;
                  end
                  default: begin
                     ev_in[0]  = rep;
                     ev_cnt_in = 2'd1;
                     state_in  = ST_EMIT;
                  end
               endcase
            end
         end
         ST_REL: begin
            op         = OP_RELEASE;
            sel_cnt_in = '0;
            state_in   = ST_SEL;
         end
         ST_SEL: begin
            sel_cnt_in = sel_cnt_ff + IDW'(1);
            if (sel_cnt_ff == IDW'(MAX_TASKS - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sel != running_ff) begin
               if (time_ff != start_ff) begin
                  ev_in[0]  = slice_ev(running_ff, time_ff - start_ff,
                                       running_ff == IDLE_CODE ? RSN_END : RSN_PREEMPT);
                  ev_cnt_in = 2'd1;
               end
               st         = time_ff;
               running_in = sel;
            end
            start_in = st;
            if (sel != IDLE_CODE) begin
               op     = OP_RUN;
               op_idx = sel;
               if (ch_rem[MAX_TASKS] == 16'd1) begin
                  // Finishing slice always has at least one tick.
                  ev_in[ev_cnt_in[0]] = slice_ev(sel, t_next - st, RSN_FINISH);
                  ev_cnt_in  = ev_cnt_in + 2'd1;
                  running_in = IDLE_CODE;
                  start_in   = t_next;
               end
            end
            state_in = ST_MISS;
         end
         ST_MISS: begin
            op = OP_MISS;
            if (running_ff != IDLE_CODE && run_hit) begin
               ev_in[ev_cnt_ff[0]] = slice_ev(running_ff, t_next - start_ff, RSN_MISS);
               ev_cnt_in  = ev_cnt_ff + 2'd1;
               running_in = IDLE_CODE;
               start_in   = t_next;
            end
            time_in  = t_next;
            state_in = (ev_cnt_in == 2'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in       = ev_ff[ev_ptr_ff];
               rsp_last_in  = ({1'b0, ev_ptr_ff} == ev_cnt_ff - 2'd1);
               rsp_valid_in = 1'b1;
               ev_ptr_in    = ev_ptr_ff + 1'b1;
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= IDLE_CODE;
         start_ff     <= '0;
         time_ff      <= '0;
         sel_cnt_ff   <= '0;
         ev_cnt_ff    <= 2'd0;
         ev_ptr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         start_ff     <= start_in;
         time_ff      <= time_in;
         sel_cnt_ff   <= sel_cnt_in;
         ev_cnt_ff    <= ev_cnt_in;
         ev_ptr_ff    <= ev_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ev_ff       <= ev_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign ch_valid[0] = 1'b0;
   assign ch_idx[0]   = '0;
   assign ch_key[0]   = '0;
   assign ch_rem[0]   = '0;

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      pts_cell #(
         .INDEX     (g),
         .IDW       (IDW),
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .op_idx      (op_idx),
         .t_now       (time_ff),
         .t_next      (t_next),
         .ld_period   (req_ch.period),
         .ld_deadline (req_ch.deadline),
         .ld_burst    (req_ch.burst),
         .task_count  (task_count_ff),
         .policy_mode (policy_ff),
         .ch_valid_i  (ch_valid[g]),
         .ch_idx_i    (ch_idx[g]),
         .ch_key_i    (ch_key[g]),
         .ch_rem_i    (ch_rem[g]),
         .ch_valid_o  (ch_valid[g+1]),
         .ch_idx_o    (ch_idx[g+1]),
         .ch_key_o    (ch_key[g+1]),
         .ch_rem_o    (ch_rem[g+1]),
         .miss_hit    (hit[g]),
         .completed   (comp[g]),
         .missed      (miss[g])
      );
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_ff.result_kind;
   assign rsp_ch.slot        = rsp_ff.slot;
   assign rsp_ch.idle        = rsp_ff.idle;
   assign rsp_ch.duration    = rsp_ff.duration;
   assign rsp_ch.reason      = rsp_ff.reason;
   assign rsp_ch.completed   = rsp_ff.completed;
   assign rsp_ch.missed      = rsp_ff.missed;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

// ===== rtl/pts_checker.sv =====
// Port-level checks for the scheduler top level, attached by bind.
// Depends on pts_pkg and the top level's channel interfaces.
module pts_checker
   import pts_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_kind,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic       rsp_idle,
   input logic [3:0] rsp_slot,
   input logic [31:0] rsp_duration,
   input logic [1:0] rsp_reason
);

   // A tick beat keeps the sequencer busy, so no request is accepted right after it.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_TICK |=> !req_ready)
      else $error("request accepted right after a tick");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_report_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_duration == 32'd0 && !rsp_idle &&
      rsp_reason == RSN_END)
      else $error("malformed counter report");

   a_idle_slice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_idle |-> rsp_slot == 4'd0 && !rsp_result_kind &&
      (rsp_reason == RSN_END))
      else $error("malformed idle slice");

endmodule

bind periodic_task_scheduler_rm_edf_core pts_checker u_pts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_kind        (req_ch.kind),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_result_kind (rsp_ch.result_kind),
   .rsp_idle        (rsp_ch.idle),
   .rsp_slot        (rsp_ch.slot),
   .rsp_duration    (rsp_ch.duration),
   .rsp_reason      (rsp_ch.reason)
);
